>>> src/mks_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mks_pkg
// Shared types, constants and helpers of the 4x4 matrix keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

    localparam logic [3:0]  ALL_HIGH        = 4'hF;
    localparam logic [15:0] DEBOUNCE_RESET  = 16'd20;
    localparam logic [63:0] KEY_MAP_RESET   = 64'hFEDC_BA98_7654_3210;

    // configuration register indexes
    localparam logic [1:0]  CFG_DEBOUNCE    = 2'd0;
    localparam logic [1:0]  CFG_KEY_MAP     = 2'd1;

    typedef enum logic [6:0] {
        PH_IDLE_SCAN    = 7'b000_0001,
        PH_IDLE_SETTLE  = 7'b000_0010,
        PH_HOLD_SCAN    = 7'b000_0100,
        PH_HOLD_SETTLE  = 7'b000_1000,
        PH_REL_WAIT     = 7'b001_0000,
        PH_FINAL_SCAN   = 7'b010_0000,
        PH_FINAL_SETTLE = 7'b100_0000
    } phase_t;

    typedef enum logic [1:0] {
        SCAN_BUSY  = 2'd0,
        SCAN_FOUND = 2'd1,
        SCAN_NONE  = 2'd2
    } scan_res_t;

    typedef enum logic [1:0] {
        BASE_IDLE  = 2'd0,
        BASE_HOLD  = 2'd1,
        BASE_FINAL = 2'd2
    } scan_base_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  row;
        logic [15:0] settle;
        logic [3:0]  held;
    } scan_state_t;

    typedef struct packed {
        logic [3:0] row_drive;
        logic       key_valid;
        logic [3:0] key_code;
    } scan_result_t;

    function automatic logic [3:0] code_of(input logic [63:0] key_map,
                                           input logic [3:0]  idx);
        code_of = key_map[{idx, 2'b00} +: 4];
    endfunction

endpackage
`default_nettype wire

>>> src/mks_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mks_step
// Next-state and result logic for one column sample of the keypad scanner.
// ----------------------------------------------------------------------------
module mks_step
    import mks_pkg::*;
(
    input  scan_state_t  cur,
    input  logic [3:0]   column_levels,
    input  logic [15:0]  debounce_ticks,
    input  logic [63:0]  key_map,
    output scan_state_t  nxt,
    output scan_result_t res
);

    always_comb
    begin
        logic       run;
        logic       in_scan;
        scan_base_t base;
        phase_t     ph_scan;
        phase_t     ph_settle;
        logic [1:0] row;
        logic [3:0] lows;
        logic [1:0] col;
        logic       one_low;
        logic [3:0] idx;
        scan_res_t  r;

        nxt       = cur;
        res.key_valid = 1'b0;
        res.key_code  = 4'd0;
        run       = 1'b1;
        in_scan   = 1'b1;
        base      = BASE_IDLE;
        row       = cur.row;
        r         = SCAN_BUSY;
        lows      = ~column_levels;
        idx       = 4'd0;

        case (cur.phase)
            PH_IDLE_SCAN:
            begin
                in_scan = 1'b1;
                base    = BASE_IDLE;
            end
            PH_IDLE_SETTLE:
            begin
                in_scan = 1'b0;
                base    = BASE_IDLE;
            end
            PH_HOLD_SCAN:
            begin
                in_scan = 1'b1;
                base    = BASE_HOLD;
            end
            PH_HOLD_SETTLE:
            begin
                in_scan = 1'b0;
                base    = BASE_HOLD;
            end
            PH_FINAL_SCAN:
            begin
                in_scan = 1'b1;
                base    = BASE_FINAL;
            end
            PH_FINAL_SETTLE:
            begin
                in_scan = 1'b0;
                base    = BASE_FINAL;
            end
            PH_REL_WAIT:
            begin
                if (cur.settle != 16'd0)
                begin
                    nxt.settle = cur.settle - 16'd1;
                    run        = 1'b0;
                end
                else
                begin
                    // wait over: final scan starts this tick at row 0
                    in_scan = 1'b1;
                    base    = BASE_FINAL;
                    row     = 2'd0;
                    nxt.row = 2'd0;
                end
            end
            default:
            begin
                nxt.phase = PH_IDLE_SCAN;
                nxt.row   = 2'd0;
                run       = 1'b0;
            end
        endcase

        case (base)
            BASE_HOLD:
            begin
                ph_scan   = PH_HOLD_SCAN;
                ph_settle = PH_HOLD_SETTLE;
            end
            BASE_FINAL:
            begin
                ph_scan   = PH_FINAL_SCAN;
                ph_settle = PH_FINAL_SETTLE;
            end
            default:
            begin
                ph_scan   = PH_IDLE_SCAN;
                ph_settle = PH_IDLE_SETTLE;
            end
        endcase

        case (lows)
            4'b0001: begin col = 2'd0; one_low = 1'b1; end
            4'b0010: begin col = 2'd1; one_low = 1'b1; end
            4'b0100: begin col = 2'd2; one_low = 1'b1; end
            4'b1000: begin col = 2'd3; one_low = 1'b1; end
            default: begin col = 2'd0; one_low = 1'b0; end
        endcase

        if (run)
        begin
            logic advance;
            advance = 1'b0;
            nxt.phase = in_scan ? ph_scan : ph_settle;
            if (in_scan)
            begin
                if (column_levels != ALL_HIGH)
                begin
                    nxt.phase  = ph_settle;
                    nxt.settle = debounce_ticks;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            else if (cur.settle != 16'd0)
            begin
                nxt.settle = cur.settle - 16'd1;
            end
            else
            begin
                nxt.phase = ph_scan;
                if (one_low)
                begin
                    idx     = {row, col};
                    nxt.row = 2'd0;
                    r       = SCAN_FOUND;
                end
                else
                begin
                    advance = 1'b1;
                end
            end

            if (advance)
            begin
                if (row == 2'd3)
                begin
                    nxt.row = 2'd0;
                    r       = SCAN_NONE;
                end
                else
                begin
                    nxt.row = row + 2'd1;
                end
            end

            case (base)
                BASE_HOLD:
                begin
                    if (r == SCAN_FOUND &&
                        code_of(key_map, idx) == code_of(key_map, cur.held))
                    begin
                        nxt.phase = PH_HOLD_SCAN;
                        nxt.row   = 2'd0;
                    end
                    else if (r != SCAN_BUSY)
                    begin
                        nxt.phase  = PH_REL_WAIT;
                        nxt.settle = debounce_ticks;
                        nxt.row    = 2'd0;
                    end
                end
                BASE_FINAL:
                begin
                    if (r == SCAN_NONE)
                    begin
                        res.key_valid = 1'b1;
                        res.key_code  = code_of(key_map, cur.held);
                    end
                    if (r != SCAN_BUSY)
                    begin
                        nxt.phase = PH_IDLE_SCAN;
                        nxt.row   = 2'd0;
                    end
                end
                default:
                begin
                    if (r == SCAN_FOUND)
                    begin
                        nxt.held  = idx;
                        nxt.phase = PH_HOLD_SCAN;
                        nxt.row   = 2'd0;
                    end
                end
            endcase
        end

        res.row_drive = ~(4'b0001 << nxt.row);
    end

endmodule
`default_nettype wire

>>> src/matrix_keypad_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// 4x4 key matrix scanner with debounce, release detection and a code map.
// ----------------------------------------------------------------------------
// The result of an accepted input transaction is registered in the output register.
// Throughput: one transaction per cycle unless out_ready stalls it; the state
//   update is a single pass of the step logic from state to output register.
// Reset (rst_n, async): idle scanning at row 0, debounce 20, identity map.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner
    import mks_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  column_levels,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       row_drive,
    output logic             key_valid,
    output logic [3:0]       key_code
);

    logic [15:0]  debounce_reg;
    logic [63:0]  key_map_reg;
    scan_state_t  state_reg;
    scan_state_t  state_next;
    scan_result_t result_next;
    scan_result_t result_reg;
    logic         out_valid_reg;
    logic         in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            key_map_reg  <= KEY_MAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_reg <= cfg_data[15:0];
                CFG_KEY_MAP:  key_map_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    mks_step u_step (
        .cur            (state_reg),
        .column_levels  (column_levels),
        .debounce_ticks (debounce_reg),
        .key_map        (key_map_reg),
        .nxt            (state_next),
        .res            (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase  <= PH_IDLE_SCAN;
            state_reg.row    <= 2'd0;
            state_reg.settle <= 16'd0;
            state_reg.held   <= 4'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_drive = result_reg.row_drive;
    assign key_valid = result_reg.key_valid;
    assign key_code  = result_reg.key_code;

`ifndef NO_ASSERTIONS
    // a release is only reported out of the final scan
    a_valid_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && result_next.key_valid |->
            (state_reg.phase == PH_FINAL_SCAN || state_reg.phase == PH_FINAL_SETTLE ||
             state_reg.phase == PH_REL_WAIT))
        else $error("key_valid outside final scan");

    a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && result_next.key_valid |=> state_reg.phase == PH_IDLE_SCAN)
        else $error("scanner not idle after key release");

    a_one_row_driven: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $countones(result_reg.row_drive) == 3)
        else $error("row_drive does not select exactly one row");

    a_code_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.key_valid |-> result_reg.key_code == 4'd0)
        else $error("key_code set without key_valid");
`endif

endmodule
`default_nettype wire

>>> bench/keypad_scan_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_scan_checker
// Watches the configuration port and both channels of the keypad scanner.
// Keeps its own copy of the scan state and the registers, predicts the result
// of every accepted column sample, and compares each accepted result against
// the oldest prediction. It also exports the row that the scanner will drive
// next, so that the keypad model in the bench can answer with the right row.
// ----------------------------------------------------------------------------
module keypad_scan_checker
    import mks_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [3:0]  column_levels,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [3:0]  row_drive,
    input  wire logic        key_valid,
    input  wire logic [3:0]  key_code,
    output logic [1:0]       row_after,
    output int               pending,
    output int               errors
);

    typedef struct packed {
        scan_state_t  st;
        scan_result_t res;
    } scan_step_t;

    scan_state_t  scan_q;
    logic [15:0]  debounce_q;
    logic [63:0]  key_map_q;
    scan_step_t   step_next;
    scan_result_t result_q[$];

    function automatic logic [3:0] mapped_code(input logic [63:0] map,
                                               input logic [3:0]  idx);
        return 4'(map >> (32'(idx) * 4));
    endfunction

    // One column sample through the scanner: new state and the result it makes.
    function automatic scan_step_t scan_step(input scan_state_t s,
                                             input logic [15:0] deb,
                                             input logic [63:0] map,
                                             input logic [3:0]  cols);
        scan_step_t o;
        scan_res_t  res;
        phase_t     scan_ph;
        phase_t     settle_ph;
        logic [3:0] lows;
        logic [3:0] hit_idx;
        logic       run;
        logic       done;
        o.st = s;
        o.res.key_valid = 1'b0;
        o.res.key_code = 4'd0;
        res = SCAN_BUSY;
        hit_idx = 4'd0;
        lows = ~cols;
        run = 1'b1;
        done = 1'b0;
        scan_ph = PH_IDLE_SCAN;
        settle_ph = PH_IDLE_SETTLE;
        case (s.phase)
            PH_REL_WAIT:
                if (s.settle != 16'd0)
                begin
                    o.st.settle = s.settle - 16'd1;
                    run = 1'b0;
                end
                else
                begin
                    o.st.phase = PH_FINAL_SCAN;
                    o.st.row = 2'd0;
                end
            PH_IDLE_SCAN, PH_IDLE_SETTLE, PH_HOLD_SCAN, PH_HOLD_SETTLE,
            PH_FINAL_SCAN, PH_FINAL_SETTLE: ;
            default:
            begin
                o.st.phase = PH_IDLE_SCAN;
                o.st.row = 2'd0;
                run = 1'b0;
            end
        endcase
        if (run)
        begin
            case (o.st.phase)
                PH_IDLE_SCAN, PH_IDLE_SETTLE:
                begin
                    scan_ph = PH_IDLE_SCAN;
                    settle_ph = PH_IDLE_SETTLE;
                end
                PH_HOLD_SCAN, PH_HOLD_SETTLE:
                begin
                    scan_ph = PH_HOLD_SCAN;
                    settle_ph = PH_HOLD_SETTLE;
                end
                default:
                begin
                    scan_ph = PH_FINAL_SCAN;
                    settle_ph = PH_FINAL_SETTLE;
                end
            endcase
            if (o.st.phase == scan_ph)
            begin
                if (cols != ALL_HIGH)
                begin
                    o.st.phase = settle_ph;
                    o.st.settle = deb;
                    done = 1'b1;
                end
            end
            else if (o.st.settle != 16'd0)
            begin
                o.st.settle = o.st.settle - 16'd1;
                done = 1'b1;
            end
            else
            begin
                // resample: only a single low column counts as a key
                o.st.phase = scan_ph;
                if (lows != 4'd0 && (lows & (lows - 4'd1)) == 4'd0)
                begin
                    for (int j = 0; j < 4; j++)
                        if (lows[j])
                            hit_idx = {o.st.row, 2'(j)};
                    o.st.row = 2'd0;
                    res = SCAN_FOUND;
                    done = 1'b1;
                end
            end
            if (!done)
            begin
                if (o.st.row == 2'd3)
                begin
                    o.st.row = 2'd0;
                    res = SCAN_NONE;
                end
                else
                    o.st.row = o.st.row + 2'd1;
            end
            case (scan_ph)
                PH_IDLE_SCAN:
                    if (res == SCAN_FOUND)
                    begin
                        o.st.held = hit_idx;
                        o.st.phase = PH_HOLD_SCAN;
                        o.st.row = 2'd0;
                    end
                PH_HOLD_SCAN:
                    // same key means same mapped code
                    if (res == SCAN_FOUND &&
                        mapped_code(map, hit_idx) == mapped_code(map, o.st.held))
                    begin
                        o.st.phase = PH_HOLD_SCAN;
                        o.st.row = 2'd0;
                    end
                    else if (res != SCAN_BUSY)
                    begin
                        o.st.phase = PH_REL_WAIT;
                        o.st.settle = deb;
                        o.st.row = 2'd0;
                    end
                default:
                begin
                    if (res == SCAN_NONE)
                    begin
                        o.res.key_valid = 1'b1;
                        o.res.key_code = mapped_code(map, o.st.held);
                    end
                    if (res != SCAN_BUSY)
                    begin
                        o.st.phase = PH_IDLE_SCAN;
                        o.st.row = 2'd0;
                    end
                end
            endcase
        end
        o.res.row_drive = ~(4'b0001 << o.st.row);
        return o;
    endfunction

    assign step_next = scan_step(scan_q, debounce_q, key_map_q, column_levels);
    assign row_after = step_next.st.row;

    always @(posedge clk or negedge rst_n)
    begin : watch
        scan_result_t want;
        if (!rst_n)
        begin
            scan_q <= '{phase: PH_IDLE_SCAN, row: 2'd0, settle: 16'd0, held: 4'd0};
            debounce_q <= DEBOUNCE_RESET;
            key_map_q <= KEY_MAP_RESET;
            pending <= 0;
            errors = 0;
        end
        else
        begin
            // retire the result before queuing a new one: the result leaving
            // at this edge always belongs to an older transaction
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result row_drive %h key_valid %b key_code %h",
                                 $time, row_drive, key_valid, key_code);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (want.row_drive != row_drive || want.key_valid != key_valid ||
                        want.key_code != key_code)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch row_drive %h/%h key_valid %b/%b key_code %h/%h (exp/got)",
                                     $time, want.row_drive, row_drive, want.key_valid,
                                     key_valid, want.key_code, key_code);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                result_q.push_back(step_next.res);
                scan_q <= step_next.st;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE: debounce_q <= cfg_data[15:0];
                    CFG_KEY_MAP:  key_map_q <= cfg_data;
                    default: ;
                endcase
            end
            pending <= result_q.size();
        end
    end

endmodule

>>> bench/tb_matrix_keypad_scanner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_keypad_scanner
// Drives the keypad scanner from a model of a 4x4 key matrix: the bench keeps
// a set of pressed keys and answers each scan tick with the column levels of
// the row being driven. Clean presses, multi-key presses, key switches,
// contact bounce, map rewrites during a press and raw noise are mixed over
// several debounce and map settings. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_matrix_keypad_scanner
    import mks_pkg::*;
();

    localparam int ITEMS      = 650;
    localparam int CALM_AFTER = 560;
    localparam int QUIET_AT   = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_DEBOUNCE;
    logic [63:0] cfg_data = 64'd0;
    logic        in_valid = 1'b0;
    logic [3:0]  column_levels = ALL_HIGH;
    logic        out_ready = 1'b0;
    wire logic       in_ready;
    wire logic       out_valid;
    wire logic [3:0] row_drive;
    wire logic       key_valid;
    wire logic [3:0] key_code;

    logic [1:0]  row_after;
    int          pending;
    int          errors;

    // keypad model
    logic [15:0] keys_down = 16'd0;
    logic [1:0]  drive_row = 2'd0;
    logic [15:0] debounce_now = DEBOUNCE_RESET;
    bit          bouncy = 1'b0;
    bit          noisy = 1'b0;
    bit          calm = 1'b0;
    bit          quiet_done = 1'b0;
    int          idle_odds = 12;
    int          stall_odds = 12;
    int          sent = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    matrix_keypad_scanner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .column_levels (column_levels),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .row_drive     (row_drive),
        .key_valid     (key_valid),
        .key_code      (key_code)
    );

    keypad_scan_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .column_levels (column_levels),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .row_drive     (row_drive),
        .key_valid     (key_valid),
        .key_code      (key_code),
        .row_after     (row_after),
        .pending       (pending),
        .errors        (errors)
    );

    function automatic logic [3:0] column_pattern();
        logic [3:0] lv;
        lv = ~keys_down[4 * drive_row +: 4];
        if (noisy)
            lv = 4'($urandom_range(0, 15));
        else if (bouncy && $urandom_range(0, 7) == 0)
            lv = lv ^ 4'($urandom_range(1, 15));
        return lv;
    endfunction

    function automatic logic [63:0] random_map();
        logic [63:0] m;
        case ($urandom_range(0, 5))
            0: m = 64'd0;
            1: m = '1;
            2: m = KEY_MAP_RESET;
            3:
            begin
                // only two codes in use, so different keys often look alike
                m = 64'd0;
                for (int i = 0; i < 16; i++)
                    m[4 * i +: 4] = 4'($urandom_range(0, 1));
            end
            default: m = {$urandom, $urandom};
        endcase
        return m;
    endfunction

    // one scan tick: present the columns of the driven row, wait for acceptance
    task automatic send_tick();
        int gap;
        if (!calm && $urandom_range(1, idle_odds) == 1)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        column_levels <= column_pattern();
        do
            @(posedge clk);
        while (!in_ready);
        drive_row = row_after;
        sent++;
        calm = (sent >= CALM_AFTER);
    endtask

    task automatic ticks(input int n);
        repeat (n) send_tick();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] deb, input logic [63:0] map);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data <= {48'd0, deb};
        @(posedge clk);
        cfg_index <= CFG_KEY_MAP;
        cfg_data <= map;
        @(posedge clk);
        cfg_we <= 1'b0;
        debounce_now = deb;
    endtask

    task automatic key_episode();
        int          hold;
        int          rest;
        logic [3:0]  k;
        logic [3:0]  k2;
        k = 4'($urandom_range(0, 15));
        k2 = 4'($urandom_range(0, 15));
        hold = $urandom_range(1, 3 * (debounce_now + 6));
        case ($urandom_range(0, 9))
            4:
            begin
                if ($urandom_range(0, 1) == 0)
                    keys_down = 16'hF << (4 * k[3:2]);
                else
                    keys_down = (16'd1 << k) | (16'd1 << {k[3:2], k2[1:0]});
                ticks(hold);
            end
            5:
            begin
                keys_down = 16'd1 << k;
                ticks(hold);
                keys_down = 16'd1 << k2;
                ticks($urandom_range(1, 3 * (debounce_now + 6)));
            end
            6:
            begin
                noisy = 1'b1;
                ticks($urandom_range(6, 24));
                noisy = 1'b0;
            end
            7:
            begin
                keys_down = 16'd1 << k;
                ticks(hold);
                drain();
                configure(debounce_now, random_map());
                ticks($urandom_range(1, hold));
            end
            8, 9:
            begin
                keys_down = 16'($urandom);
                ticks(hold);
            end
            default:
            begin
                keys_down = 16'd1 << k;
                ticks(hold);
            end
        endcase
        keys_down = 16'd0;
        // a short rest lets a new press land in the last scan
        if ($urandom_range(0, 3) == 0)
            rest = $urandom_range(0, 2 * debounce_now + 12);
        else
            rest = 2 * debounce_now + 12 + $urandom_range(0, 6);
        ticks(rest);
    endtask

    initial
    begin
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(1, stall_odds) == 1)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero debounce, corner keys, map rewritten during a press
        configure(16'd0, KEY_MAP_RESET);
        keys_down = 16'h0001;
        ticks(3);
        keys_down = 16'd0;
        ticks(8);
        keys_down = 16'h8000;
        ticks(5);
        drain();
        configure(16'd0, '1);
        ticks(1);
        keys_down = 16'd0;
        ticks(10);

        while (sent < ITEMS)
        begin
            drain();
            if (!quiet_done && sent >= QUIET_AT)
            begin
                // longest debounce, only with all keys up so no settle starts
                bouncy = 1'b0;
                noisy = 1'b0;
                ticks(4 * (debounce_now + 4) + 8);
                drain();
                configure(16'hFFFF, random_map());
                ticks(12);
                drain();
                quiet_done = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: configure(16'd0, random_map());
                4, 5, 6:    configure(16'($urandom_range(1, 3)), random_map());
                7:          configure(16'($urandom_range(4, 6)), random_map());
                8:          configure(DEBOUNCE_RESET, random_map());
                default:    configure(16'($urandom_range(10, 12)), random_map());
            endcase
            bouncy = ($urandom_range(0, 2) == 0);
            idle_odds = $urandom_range(3, 40);
            stall_odds = $urandom_range(3, 40);
            repeat ($urandom_range(2, 5))
                if (sent < ITEMS)
                    key_episode();
        end

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("** matrix_keypad_scanner: PASSED **");
        else
            $display("** matrix_keypad_scanner: FAILED **");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("** matrix_keypad_scanner: FAILED **");
        $finish;
    end

endmodule
